/* rtl/time_based_event_debouncer_macros.svh */
// assertion macros for the event debouncer
// no dependencies; included by the top level only
`ifndef TIME_BASED_EVENT_DEBOUNCER_MACROS_SVH
`define TIME_BASED_EVENT_DEBOUNCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define TBD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define TBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/tbd_pkg.sv */
// shared types and constants of the event debouncer
// no dependencies
package tbd_pkg;

  localparam int unsigned EVENT_COUNT_DEF = 32;
  localparam int unsigned MAX_RESULTS     = 32;
  localparam int unsigned CNT_W           = $clog2(MAX_RESULTS + 1);
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned ID_W            = 8;

  localparam logic [TIME_W-1:0] FAIL_TIME_RESET = 32'd100;
  localparam logic [TIME_W-1:0] PASS_TIME_RESET = 32'd100;

  // input selector carried on s_tuser
  localparam logic FUNC_REPORT = 1'b0;
  localparam logic FUNC_TICK   = 1'b1;

  // result kind carried on m_tuser
  localparam logic KIND_ACK       = 1'b0;
  localparam logic KIND_QUALIFIED = 1'b1;

  // report status codes
  localparam logic [1:0] STATUS_FAILED    = 2'd0;
  localparam logic [1:0] STATUS_PASSED    = 2'd1;
  localparam logic [1:0] STATUS_PREFAILED = 2'd2;
  localparam logic [1:0] STATUS_PREPASSED = 2'd3;

  // qualified status codes
  localparam logic QSTAT_FAILED = 1'b0;
  localparam logic QSTAT_PASSED = 1'b1;

  // configuration register indexes
  localparam logic REG_FAIL_TIME = 1'b0;
  localparam logic REG_PASS_TIME = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPORT,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  // one timer table entry
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] duration;
  } timer_entry_t;

endpackage

/* rtl/time_based_event_debouncer.sv */
// Event debouncer with one timer per event number. A report item (s_tuser 0) is accepted,
// then updates the table and loads the acknowledge, waiting while an earlier result still
// holds the output register. A tick item (s_tuser 1) walks the table one entry per cycle,
// pausing while a held expiry waits on a busy output, through a single read port and one
// shared subtract-and-compare unit; expired entries are reported in ascending order, the
// final one with m_tlast set, and a tick with no expiry gives no result. At most
// MAX_RESULTS results come from one tick; further expired entries stay armed for a later
// tick. s_tready is high only between items; the output register lets a new item enter
// while a result waits. Debounce times are sampled when a timer starts. No clearing
// pass follows reset.
// depends on tbd_pkg, tbd_mem, tbd_cmp and the macros header
module time_based_event_debouncer #(
  parameter int unsigned EVENT_COUNT = tbd_pkg::EVENT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // event_id[7:0], status[9:8], tick_ms[41:10], zero[47:42]
  input  logic        s_tuser,   // func
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // accepted[0], out_event[8:1], out_status[9], zero[15:10]
  output logic        m_tuser,   // kind
  output logic        m_tlast,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(EVENT_COUNT);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(EVENT_COUNT - 1);

  // configuration registers
  logic [tbd_pkg::TIME_W-1:0] fail_time_ms;
  logic [tbd_pkg::TIME_W-1:0] pass_time_ms;

  // latched item
  logic [tbd_pkg::ID_W-1:0]   cur_id;
  logic [1:0]                 cur_status;
  logic [tbd_pkg::TIME_W-1:0] cur_tick;

  // per-entry flags
  logic [EVENT_COUNT-1:0] running;
  logic [EVENT_COUNT-1:0] last_failed;

  // sequencer
  tbd_pkg::state_t state, state_next;
  logic [IDX_W-1:0]          idx;
  logic [tbd_pkg::CNT_W-1:0] n_hits;

  // held expiry waiting to learn whether it is the last
  logic             pend_valid;
  logic [IDX_W-1:0] pend_event;
  logic             pend_status;

  // output register
  logic                     out_valid;
  logic                     out_kind;
  logic                     out_acc;
  logic [tbd_pkg::ID_W-1:0] out_event;
  logic                     out_status;
  logic                     out_last;

  // control from the sequencer
  logic                     in_acc;
  logic                     out_free;
  logic                     out_load;
  logic                     out_kind_next;
  logic                     out_acc_next;
  logic [tbd_pkg::ID_W-1:0] out_event_next;
  logic                     out_status_next;
  logic                     out_last_next;
  logic                     pend_load;
  logic                     pend_drop;
  logic                     scan_step;
  logic                     hit_take;
  logic                     run_set;
  logic                     mem_wen;
  logic [IDX_W-1:0]         rd_addr;

  // report decode
  logic                  id_ok;
  logic                  is_start;
  logic                  rpt_failed;
  logic [IDX_W-1:0]      rpt_idx;
  tbd_pkg::timer_entry_t wentry;

  // scan datapath
  tbd_pkg::timer_entry_t rentry;
  logic                  expired;
  logic                  hit;

  tbd_mem #(
    .DEPTH (EVENT_COUNT),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .wen   (mem_wen),
    .waddr (rpt_idx),
    .wdata (wentry),
    .raddr (rd_addr),
    .rdata (rentry)
  );

  tbd_cmp u_cmp (
    .now     (cur_tick),
    .entry   (rentry),
    .expired (expired)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_time_ms <= tbd_pkg::FAIL_TIME_RESET;
      pass_time_ms <= tbd_pkg::PASS_TIME_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tbd_pkg::REG_FAIL_TIME) begin
        fail_time_ms <= cfg_data;
      end else begin
        pass_time_ms <= cfg_data;
      end
    end
  end

  // report decode
  always_comb begin
    id_ok      = (cur_id != '0) && (cur_id < tbd_pkg::ID_W'(EVENT_COUNT));
    rpt_idx    = cur_id[IDX_W-1:0];
    rpt_failed = (cur_status == tbd_pkg::STATUS_FAILED);
    is_start   = (cur_status == tbd_pkg::STATUS_FAILED) ||
                 (cur_status == tbd_pkg::STATUS_PASSED);
    wentry.start_time = cur_tick;
    wentry.duration   = rpt_failed ? fail_time_ms : pass_time_ms;
  end

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == tbd_pkg::ST_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign hit      = running[idx] && expired && (n_hits < tbd_pkg::CNT_W'(tbd_pkg::MAX_RESULTS));

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tbd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and sequencer outputs
  always_comb begin
    state_next      = state;
    out_load        = 1'b0;
    out_kind_next   = tbd_pkg::KIND_ACK;
    out_acc_next    = 1'b0;
    out_event_next  = cur_id;
    out_status_next = tbd_pkg::QSTAT_FAILED;
    out_last_next   = 1'b1;
    pend_load       = 1'b0;
    pend_drop       = 1'b0;
    scan_step       = 1'b0;
    hit_take        = 1'b0;
    run_set         = 1'b0;
    mem_wen         = 1'b0;
    rd_addr         = idx;
    case (state)
      tbd_pkg::ST_IDLE: begin
        rd_addr = '0;
        if (in_acc) begin
          state_next = (s_tuser == tbd_pkg::FUNC_TICK) ? tbd_pkg::ST_SCAN : tbd_pkg::ST_REPORT;
        end
      end
      tbd_pkg::ST_REPORT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_acc_next = id_ok;
          if (id_ok && is_start &&
              (!running[rpt_idx] || (last_failed[rpt_idx] != rpt_failed))) begin
            mem_wen = 1'b1;
            run_set = 1'b1;
          end
          state_next = tbd_pkg::ST_IDLE;
        end
      end
      tbd_pkg::ST_SCAN: begin
        // stall only when a second expiry must push the held one out
        if (!(hit && pend_valid && !out_free)) begin
          scan_step = 1'b1;
          if (hit) begin
            hit_take  = 1'b1;
            pend_load = 1'b1;
            if (pend_valid) begin
              out_load        = 1'b1;
              out_kind_next   = tbd_pkg::KIND_QUALIFIED;
              out_event_next  = tbd_pkg::ID_W'(pend_event);
              out_status_next = pend_status;
              out_last_next   = 1'b0;
            end
          end
          if (idx == IDX_LAST) begin
            state_next = tbd_pkg::ST_FLUSH;
          end else begin
            rd_addr = idx + 1'b1;
          end
        end
      end
      tbd_pkg::ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = tbd_pkg::ST_IDLE;
        end else if (out_free) begin
          out_load        = 1'b1;
          out_kind_next   = tbd_pkg::KIND_QUALIFIED;
          out_event_next  = tbd_pkg::ID_W'(pend_event);
          out_status_next = pend_status;
          out_last_next   = 1'b1;
          pend_drop       = 1'b1;
          state_next      = tbd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tbd_pkg::ST_IDLE;
      end
    endcase
  end

  // item latch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_id     <= s_tdata[7:0];
      cur_status <= s_tdata[9:8];
      cur_tick   <= s_tdata[41:10];
    end
  end

  // scan index and per-tick result count
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      n_hits <= '0;
    end else if (in_acc) begin
      idx    <= '0;
      n_hits <= '0;
    end else begin
      if (scan_step && (idx != IDX_LAST)) begin
        idx <= idx + 1'b1;
      end
      if (hit_take) begin
        n_hits <= n_hits + 1'b1;
      end
    end
  end

  // timer flags
  always_ff @(posedge clk) begin
    if (rst) begin
      running     <= '0;
      last_failed <= '0;
    end else if (run_set) begin
      running[rpt_idx]     <= 1'b1;
      last_failed[rpt_idx] <= rpt_failed;
    end else if (hit_take) begin
      running[idx] <= 1'b0;
    end
  end

  // held expiry
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (pend_load) begin
      pend_valid <= 1'b1;
    end else if (pend_drop) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_event  <= idx;
      pend_status <= last_failed[idx] ? tbd_pkg::QSTAT_FAILED : tbd_pkg::QSTAT_PASSED;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind   <= out_kind_next;
      out_acc    <= out_acc_next;
      out_event  <= out_event_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'b0, out_status, out_event, out_acc};

  // checks
  `include "time_based_event_debouncer_macros.svh"

  `TBD_ASSERT_NOW(a_pend_in_scan, clk, rst, pend_valid, (state == tbd_pkg::ST_SCAN) || (state == tbd_pkg::ST_FLUSH))
  `TBD_ASSERT_NOW(a_hits_bounded, clk, rst, 1'b1, n_hits <= tbd_pkg::CNT_W'(tbd_pkg::MAX_RESULTS))
  `TBD_ASSERT_NEXT(a_report_ack, clk, rst, (state == tbd_pkg::ST_REPORT) && out_free, m_tvalid && (m_tuser == tbd_pkg::KIND_ACK) && m_tlast)
  `TBD_ASSERT_NEXT(a_idle_clean, clk, rst, state == tbd_pkg::ST_IDLE, !pend_valid)

endmodule

/* rtl/tbd_mem.sv */
// timer table memory: start time and duration per event
// depends on tbd_pkg
module tbd_mem #(
  parameter int unsigned DEPTH = tbd_pkg::EVENT_COUNT_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 wen,
  input  logic [AW-1:0]        waddr,
  input  tbd_pkg::timer_entry_t wdata,
  input  logic [AW-1:0]        raddr,
  output tbd_pkg::timer_entry_t rdata
);

  tbd_pkg::timer_entry_t mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tbd_cmp.sv */
// shared expiry unit: wrapped elapsed time against duration
// depends on tbd_pkg
module tbd_cmp (
  input  logic [tbd_pkg::TIME_W-1:0] now,
  input  tbd_pkg::timer_entry_t      entry,
  output logic                       expired
);

  logic [tbd_pkg::TIME_W-1:0] elapsed;

  // modulo 2^32 difference, then unsigned compare
  always_comb begin
    elapsed = now - entry.start_time;
    expired = (elapsed >= entry.duration);
  end

endmodule

/* sim/time_based_event_debouncer_test.sv */
// self-checking testbench for time_based_event_debouncer: stream driver, result checker
// and a cycle-free timer table predictor; depends on tbd_pkg and the block's RTL only
`timescale 1ns / 100ps

module time_based_event_debouncer_test;

  localparam int EVENTS = tbd_pkg::EVENT_COUNT_DEF;
  // a tick walks the whole table plus a little pipeline
  localparam int SCAN_CYCLES = EVENTS + 8;

  typedef struct {
    logic        func;
    logic [7:0]  id;
    logic [1:0]  status;
    logic [31:0] tick;
  } report_item_t;

  typedef struct {
    logic       kind;
    logic       accepted;
    logic [7:0] ev_num;
    logic       qstat;
    logic       last;
  } debounce_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;   // event_id[7:0], status[9:8], tick_ms[41:10], zero[47:42]
  logic        s_tuser = 1'b0; // func
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // accepted[0], out_event[8:1], out_status[9], zero[15:10]
  logic        m_tuser;        // kind
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = tbd_pkg::REG_FAIL_TIME;
  logic [31:0] cfg_data = '0;

  time_based_event_debouncer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // predicted timer table and debounce times
  logic        armed      [EVENTS];
  logic        timed_fail [EVENTS];
  logic [31:0] t_start    [EVENTS];
  logic [31:0] t_len      [EVENTS];
  logic [31:0] fail_ms = tbd_pkg::FAIL_TIME_RESET;
  logic [31:0] pass_ms = tbd_pkg::PASS_TIME_RESET;

  report_item_t     pending_items[$];
  debounce_result_t due_results[$];
  report_item_t     cur_item;
  int               items_loaded = 0;
  int               items_taken = 0;
  int               err_cnt = 0;
  bit               calm = 1'b0;
  int               gap_left = 0;
  int               stall_left = 0;
  logic [31:0]      clock_ms = '0;
  int unsigned      span_ms = 10;

  initial begin
    for (int i = 0; i < EVENTS; i++) begin
      armed[i] = 1'b0;
      timed_fail[i] = 1'b0;
      t_start[i] = '0;
      t_len[i] = '0;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void arm_timer(input logic [7:0] id, input logic failed,
                                    input logic [31:0] now, input logic [31:0] len);
    if (!armed[id] || timed_fail[id] != failed) begin
      armed[id] = 1'b1;
      timed_fail[id] = failed;
      t_start[id] = now;
      t_len[id] = len;
    end
  endfunction

  // expected results of one accepted item, with the table update
  function automatic void predict_debounce(input report_item_t it);
    debounce_result_t r;
    logic [31:0] elapsed;
    int n;
    n = 0;
    if (it.func == tbd_pkg::FUNC_REPORT) begin
      r = '{tbd_pkg::KIND_ACK, 1'b0, it.id, tbd_pkg::QSTAT_FAILED, 1'b1};
      if (it.id != 0 && it.id < EVENTS) begin
        r.accepted = 1'b1;
        if (it.status == tbd_pkg::STATUS_FAILED) arm_timer(it.id, 1'b1, it.tick, fail_ms);
        else if (it.status == tbd_pkg::STATUS_PASSED) arm_timer(it.id, 1'b0, it.tick, pass_ms);
      end
      due_results.push_back(r);
    end else begin
      for (int i = 0; i < EVENTS; i++) begin
        elapsed = it.tick - t_start[i];
        if (n < tbd_pkg::MAX_RESULTS && armed[i] && elapsed >= t_len[i]) begin
          armed[i] = 1'b0;
          r = '{tbd_pkg::KIND_QUALIFIED, 1'b0, 8'(i),
                timed_fail[i] ? tbd_pkg::QSTAT_FAILED : tbd_pkg::QSTAT_PASSED, 1'b0};
          due_results.push_back(r);
          n++;
        end
      end
      if (n > 0) due_results[due_results.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    err_cnt++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  // input driver: one item at a time, random gaps between items
  always @(negedge clk) begin
    if (rst || items_loaded != items_taken) begin
      // item on the bus still waits for the block
    end else if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      gap_left--;
    end else if (pending_items.size() != 0) begin
      cur_item = pending_items.pop_front();
      s_tdata  <= {6'b0, cur_item.tick, cur_item.status, cur_item.id};
      s_tuser  <= cur_item.func;
      s_tvalid <= 1'b1;
      items_loaded++;
      gap_left = idle_len(calm);
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      stall_left = idle_len(calm);
    end
  end

  // accepted input items feed the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_debounce(cur_item);
      items_taken++;
    end
  end

  // result checker
  always @(posedge clk) begin
    debounce_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result kind %0d event %0d", m_tuser, m_tdata[8:1]));
      end else begin
        want = due_results.pop_front();
        if (m_tuser !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", m_tuser, want.kind));
        if (m_tdata[0] !== want.accepted)
          flag_mismatch($sformatf("accepted %0d, want %0d", m_tdata[0], want.accepted));
        if (m_tdata[8:1] !== want.ev_num)
          flag_mismatch($sformatf("event %0d, want %0d", m_tdata[8:1], want.ev_num));
        if (m_tdata[9] !== want.qstat)
          flag_mismatch($sformatf("status %0d, want %0d (event %0d)", m_tdata[9], want.qstat,
                                  want.ev_num));
        if (m_tlast !== want.last)
          flag_mismatch($sformatf("last %0d, want %0d (event %0d)", m_tlast, want.last,
                                  want.ev_num));
      end
    end
  end

  task automatic add_report(input logic [7:0] id, input logic [1:0] status,
                            input logic [31:0] tick);
    pending_items.push_back('{tbd_pkg::FUNC_REPORT, id, status, tick});
  endtask

  task automatic add_tick(input logic [31:0] tick);
    pending_items.push_back('{tbd_pkg::FUNC_TICK, 8'($urandom), 2'($urandom), tick});
  endtask

  // wait until the block is idle, then give a silent scan time to finish
  task automatic settle();
    while (pending_items.size() != 0 || items_loaded != items_taken || due_results.size() != 0)
      @(posedge clk);
    repeat (SCAN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == tbd_pkg::REG_FAIL_TIME) fail_ms = val;
    else pass_ms = val;
  endtask

  task automatic set_times(input logic [31:0] f, input logic [31:0] p, input int unsigned span);
    write_reg(tbd_pkg::REG_FAIL_TIME, f);
    write_reg(tbd_pkg::REG_PASS_TIME, p);
    span_ms = span;
  endtask

  // random traffic: mostly valid reports and ticks on a moving clock
  task automatic run_random(input int count);
    int done;
    int r;
    int k;
    done = 0;
    while (done < count) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      if (r < 3) begin
        // every valid event from 1 to EVENTS-1 reports, then one tick follows
        for (int i = 1; i < EVENTS; i++) add_report(8'(i), 2'($urandom_range(0, 1)), clock_ms);
        clock_ms += span_ms;
        add_tick(clock_ms);
        done += EVENTS;
      end else if (r < 12) begin
        // a burst of timer starts followed by a tick
        k = $urandom_range(3, 12);
        for (int i = 0; i < k; i++)
          add_report(8'($urandom_range(1, EVENTS - 1)), 2'($urandom_range(0, 1)), clock_ms);
        clock_ms += $urandom_range(0, span_ms);
        add_tick(clock_ms);
        done += k + 1;
      end else if (r < 55) begin
        if ($urandom_range(0, 9) == 0)
          add_report($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(EVENTS, 255)),
                     2'($urandom), clock_ms);
        else
          add_report(8'($urandom_range(1, EVENTS - 1)), 2'($urandom), clock_ms);
        clock_ms += $urandom_range(0, 2);
        done++;
      end else if (r < 95) begin
        clock_ms += $urandom_range(0, span_ms);
        add_tick(clock_ms);
        done++;
      end else begin
        // noise: arbitrary fields, sometimes a jump of the clock
        if ($urandom_range(0, 1) == 0) clock_ms = $urandom;
        if ($urandom_range(0, 1) == 0) add_tick($urandom);
        else add_report(8'($urandom), 2'($urandom), $urandom);
        done++;
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset debounce times, rejected ids, statuses, wrap of the clock
    calm = 1'b0;
    add_report(8'd0, tbd_pkg::STATUS_FAILED, 32'd0);
    add_report(8'(EVENTS), tbd_pkg::STATUS_PASSED, 32'd0);
    add_report(8'd255, tbd_pkg::STATUS_PREPASSED, 32'hFFFF_FFFF);
    add_report(8'(EVENTS - 1), tbd_pkg::STATUS_FAILED, 32'd1000);
    add_report(8'd1, tbd_pkg::STATUS_PASSED, 32'd1000);
    add_report(8'd2, tbd_pkg::STATUS_PREFAILED, 32'd1000);
    add_report(8'd3, tbd_pkg::STATUS_PREPASSED, 32'd1000);
    add_tick(32'd1050);
    add_report(8'(EVENTS - 1), tbd_pkg::STATUS_FAILED, 32'd1060);
    add_report(8'd1, tbd_pkg::STATUS_FAILED, 32'd1080);
    add_tick(32'd1100);
    add_tick(32'd1180);
    add_tick(32'd1181);
    add_report(8'd5, tbd_pkg::STATUS_PASSED, 32'hFFFF_FFC0);
    add_tick(32'h0000_0023);
    add_tick(32'h0000_0024);
    add_tick($urandom);
    settle();

    // extremes: zero fail time, largest pass time
    set_times(32'd0, 32'hFFFF_FFFF, 4);
    add_report(8'd7, tbd_pkg::STATUS_FAILED, 32'd500);
    add_report(8'd8, tbd_pkg::STATUS_PASSED, 32'd500);
    add_tick(32'd500);
    add_tick(32'd499);
    add_report(8'd9, tbd_pkg::STATUS_PASSED, 32'd700);
    add_report(8'd9, tbd_pkg::STATUS_FAILED, 32'd701);
    add_tick(32'd701);
    settle();

    clock_ms = 32'd2000;
    set_times(32'd3, 32'd9, 12);
    run_random(60);
    settle();

    clock_ms = 32'hFFFF_FF00;
    set_times(32'hFFFF_FFFF, 32'd0, 6);
    run_random(60);
    settle();

    set_times($urandom_range(0, 60), $urandom_range(0, 60), 70);
    run_random(60);
    settle();

    set_times(tbd_pkg::FAIL_TIME_RESET, tbd_pkg::PASS_TIME_RESET, 130);
    run_random(60);
    settle();

    set_times($urandom, $urandom_range(0, 20), 25);
    run_random(60);
    settle();

    if (err_cnt == 0) begin
      $display("** time_based_event_debouncer: PASSED **");
    end else begin
      $display("** time_based_event_debouncer: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40_000_000;
    $display("** time_based_event_debouncer: FAILED **");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/tbd_pkg.sv
rtl/tbd_mem.sv
rtl/tbd_cmp.sv
rtl/time_based_event_debouncer.sv
sim/time_based_event_debouncer_test.sv
